[rtl/sce_pkg.sv]
// shared types and constants for the smoothed cpt estimator
`default_nettype none

package sce_pkg;

  // field widths
  localparam int PARENT_SLOTS = 4;
  localparam int SLOT_W       = 2;
  localparam int CARD_W       = 4;
  localparam int PCNT_W       = 3;
  localparam int VAL_W        = 3;
  localparam int WEIGHT_W     = 17;
  localparam int ENTRY_W      = 6;
  localparam int PROB_W       = 16;
  localparam int SUM_W        = 32;
  localparam int SPAN_W       = 16;
  localparam int SIZE_W       = 20;
  localparam int DIV_W        = 42;
  localparam int QUO_W        = 16;
  localparam int STEP_W       = 5;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_VAR_CARD     = 3'd0;
  localparam logic [2:0] REG_PARENT_COUNT = 3'd1;
  localparam logic [2:0] REG_CARD_FIRST   = 3'd2;
  localparam logic [2:0] REG_CARD_SECOND  = 3'd3;
  localparam logic [2:0] REG_CARD_THIRD   = 3'd4;
  localparam logic [2:0] REG_CARD_FOURTH  = 3'd5;

  // register reset values
  localparam logic [CARD_W-1:0] VAR_CARD_RST    = 4'd2;
  localparam logic [PCNT_W-1:0] PARENT_CNT_RST  = 3'd0;
  localparam logic [CARD_W-1:0] PARENT_CARD_RST = 4'd1;

  // smoothing constant in q.24 and clamp bounds in q0.16
  localparam logic [15:0] SMOOTH_Q24 = 16'd58720;
  localparam logic [PROB_W-1:0] CLAMP_LOW  = 16'd7;
  localparam logic [PROB_W-1:0] CLAMP_HIGH = 16'd65529;

  // serial divider step counts
  localparam logic [STEP_W-1:0] REM_STEPS  = 5'd6;
  localparam logic [STEP_W-1:0] FRAC_STEPS = 5'd16;

  typedef struct packed {
    logic [1:0]          operation;
    logic [VAL_W-1:0]    var_value;
    logic [VAL_W-1:0]    parent_value_first;
    logic [VAL_W-1:0]    parent_value_second;
    logic [VAL_W-1:0]    parent_value_third;
    logic [VAL_W-1:0]    parent_value_fourth;
    logic [WEIGHT_W-1:0] sample_weight;
    logic [ENTRY_W-1:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic              status;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  rem_init;
    logic [QUO_W-1:0]  bits_init;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COMBO,
    ST_INDEX,
    ST_REM,
    ST_FETCH,
    ST_UPDATE,
    ST_PREP,
    ST_FRAC,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/sce_ifs.sv]
// valid/ready stream interfaces for the input and result channels
`default_nettype none

interface sce_in_if;
  import sce_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sce_out_if;
  import sce_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/sce_count_mem.sv]
// single-port-write, single-port-read count memory with registered read data
`default_nettype none

module sce_count_mem #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [sce_pkg::SUM_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic [sce_pkg::SUM_W-1:0] rdata
);
  import sce_pkg::*;

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/sce_serial_div.sv]
// shared shift-subtract divider, one quotient bit per cycle
`default_nettype none

module sce_serial_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sce_pkg::div_req_t req,
  output sce_pkg::div_rsp_t rsp
);
  import sce_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  rem_nxt;
  logic [DIV_W-1:0]  div_r;
  logic [QUO_W-1:0]  bits_r;
  logic [QUO_W-1:0]  quo_r;
  logic [DIV_W-1:0]  trial;
  logic              ge;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r[DIV_W-2:0], bits_r[QUO_W-1]};
    ge      = (trial >= div_r);
    rem_nxt = ge ? (trial - div_r) : trial;
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.rem_init;
      bits_r <= req.bits_init;
      div_r  <= req.divisor;
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      bits_r <= {bits_r[QUO_W-2:0], 1'b0};
      quo_r  <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

[rtl/smoothed_cpt_estimator.sv]
// smoothed_cpt_estimator: weighted count tables and smoothed probability readout
//
// One item is taken on in_ch at a time; each item gives exactly one beat on out_ch.
// A clear item zeroes both count memories, a sample item adds its weight to one
// entry count and to its parent-combination count, a read item returns
// (num + 0.0035) / (den + 0.0035 * card) in q0.16, clamped to [7, 65529].
// From accept to result, a sample item takes four parent digit steps, then a
// read-modify-write of both memories; a read item takes a remainder division and,
// unless the ratio reaches one, a fraction division in the shared serial divider;
// a clear item zeroes one memory row per cycle. The serial divider and the single
// memory port pair set the pace. After reset the block sweeps both memories to
// zero and takes no item meanwhile; register writes are taken at any time, and
// in_ch ready stays low after a write while the table size is derived.
// A finished result waits in the output register while out_ch is stalled; the
// next item is accepted meanwhile and holds in its last step until the beat goes.
`default_nettype none

module smoothed_cpt_estimator #(
  parameter int TABLE_DEPTH = 64,
  parameter int MAX_PARENTS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sce_in_if.sink                         in_ch,
  sce_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sce_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sce_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sce_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sce_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int IDX_W = SPAN_W + VAL_W;

  // configuration registers
  logic [CARD_W-1:0] var_card_r;
  logic [PCNT_W-1:0] parent_cnt_r;
  logic [CARD_W-1:0] pcard_r [PARENT_SLOTS];
  logic [1:0]        settle_r;
  logic              wr_en;
  logic [2:0]        reg_sel;

  // derived table geometry
  logic [CARD_W-1:0]   eff_card [PARENT_SLOTS];
  logic [2*CARD_W-1:0] p01_r;
  logic [2*CARD_W-1:0] p23_r;
  logic [SPAN_W-1:0]   span_r;
  logic [SIZE_W-1:0]   size_r;
  logic [SIZE_W-1:0]   size_nxt;
  logic                usable_r;
  logic                usable_nxt;

  // sequencer
  state_t              state_r;
  state_t              state_nxt;
  in_item_t            item_r;
  logic [SLOT_W-1:0]   k_r;
  logic [SPAN_W-1:0]   combo_r;
  logic                combo_ok_r;
  logic [AW-1:0]       ent_addr_r;
  logic [AW-1:0]       cmb_addr_r;
  logic [AW-1:0]       clr_cnt_r;
  logic                clear_reply_r;
  logic [DIV_W-1:0]    num_r;
  logic [DIV_W-1:0]    den_r;
  logic [PROB_W-1:0]   res_prob_r;
  logic                res_status_r;
  out_item_t           out_r;
  logic                out_valid_r;

  // combinational helpers
  logic                in_rdy;
  logic                in_acc;
  logic                out_free;
  logic                read_bad;
  logic                sample_bad;
  logic [VAL_W-1:0]    pv_sel;
  logic [CARD_W-1:0]   card_sel;
  logic                use_slot;
  logic                pv_ok;
  logic [SPAN_W-1:0]   combo_step;
  logic [IDX_W-1:0]    idx_full;
  logic [SUM_W:0]      ent_sum;
  logic [SUM_W:0]      cmb_sum;
  logic [SUM_W-1:0]    ent_new;
  logic [SUM_W-1:0]    cmb_new;
  logic [SIZE_W-1:0]   smooth_den;
  logic [PROB_W-1:0]   prob_clamped;

  // memory and divider ports
  logic                ent_we;
  logic                cmb_we;
  logic [AW-1:0]       ent_waddr;
  logic [AW-1:0]       cmb_waddr;
  logic [SUM_W-1:0]    ent_wdata;
  logic [SUM_W-1:0]    cmb_wdata;
  logic [SUM_W-1:0]    ent_rdata;
  logic [SUM_W-1:0]    cmb_rdata;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // apb register write and readback
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_card_r   <= VAR_CARD_RST;
      parent_cnt_r <= PARENT_CNT_RST;
      for (int i = 0; i < PARENT_SLOTS; i++) begin
        pcard_r[i] <= PARENT_CARD_RST;
      end
      settle_r     <= 2'd3;
    end else begin
      if (wr_en) begin
        settle_r <= 2'd3;
        unique case (reg_sel)
          REG_VAR_CARD:     var_card_r   <= pwdata[CARD_W-1:0];
          REG_PARENT_COUNT: parent_cnt_r <= pwdata[PCNT_W-1:0];
          REG_CARD_FIRST:   pcard_r[0]   <= pwdata[CARD_W-1:0];
          REG_CARD_SECOND:  pcard_r[1]   <= pwdata[CARD_W-1:0];
          REG_CARD_THIRD:   pcard_r[2]   <= pwdata[CARD_W-1:0];
          REG_CARD_FOURTH:  pcard_r[3]   <= pwdata[CARD_W-1:0];
          default: ;
        endcase
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_VAR_CARD:     prdata = CFG_DATA_W'(var_card_r);
      REG_PARENT_COUNT: prdata = CFG_DATA_W'(parent_cnt_r);
      REG_CARD_FIRST:   prdata = CFG_DATA_W'(pcard_r[0]);
      REG_CARD_SECOND:  prdata = CFG_DATA_W'(pcard_r[1]);
      REG_CARD_THIRD:   prdata = CFG_DATA_W'(pcard_r[2]);
      REG_CARD_FOURTH:  prdata = CFG_DATA_W'(pcard_r[3]);
      default:          prdata = '0;
    endcase
  end

  // table geometry: parent span and table size, three registered steps
  always_comb begin
    for (int i = 0; i < PARENT_SLOTS; i++) begin
      eff_card[i] = (PCNT_W'(i) < parent_cnt_r) ? pcard_r[i] : 4'd1;
    end
    size_nxt   = SIZE_W'(span_r) * SIZE_W'(var_card_r);
    usable_nxt = (32'(parent_cnt_r) <= 32'(MAX_PARENTS))
              && (parent_cnt_r <= PCNT_W'(PARENT_SLOTS))
              && (span_r != '0) && (var_card_r != '0)
              && (32'(size_nxt) <= 32'(TABLE_DEPTH));
  end

  always_ff @(posedge clk) begin
    p01_r    <= (2*CARD_W)'(eff_card[0]) * (2*CARD_W)'(eff_card[1]);
    p23_r    <= (2*CARD_W)'(eff_card[2]) * (2*CARD_W)'(eff_card[3]);
    span_r   <= SPAN_W'(p01_r) * SPAN_W'(p23_r);
    size_r   <= size_nxt;
    usable_r <= usable_nxt;
  end

  // handshake
  assign in_rdy       = (state_r == ST_IDLE) && (settle_r == 2'd0);
  assign in_ch.ready  = in_rdy;
  assign in_acc       = in_ch.valid && in_rdy;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // range checks
  assign read_bad   = !usable_r
                   || (SIZE_W'(in_ch.data.entry_index) >= size_r);
  assign sample_bad = !usable_r
                   || (CARD_W'(item_r.var_value) >= var_card_r)
                   || !combo_ok_r;

  // one parent digit per cycle
  always_comb begin
    unique case (k_r)
      2'd0: begin
        pv_sel   = item_r.parent_value_first;
        card_sel = pcard_r[0];
      end
      2'd1: begin
        pv_sel   = item_r.parent_value_second;
        card_sel = pcard_r[1];
      end
      2'd2: begin
        pv_sel   = item_r.parent_value_third;
        card_sel = pcard_r[2];
      end
      default: begin
        pv_sel   = item_r.parent_value_fourth;
        card_sel = pcard_r[3];
      end
    endcase
    use_slot   = PCNT_W'(k_r) < parent_cnt_r;
    pv_ok      = CARD_W'(pv_sel) < card_sel;
    combo_step = SPAN_W'(combo_r * SPAN_W'(card_sel)) + SPAN_W'(pv_sel);
  end

  // entry index with the variable as top digit
  assign idx_full = IDX_W'(item_r.var_value) * IDX_W'(span_r) + IDX_W'(combo_r);

  // saturating count update
  always_comb begin
    ent_sum = (SUM_W+1)'(ent_rdata) + (SUM_W+1)'(item_r.sample_weight);
    cmb_sum = (SUM_W+1)'(cmb_rdata) + (SUM_W+1)'(item_r.sample_weight);
    ent_new = ent_sum[SUM_W] ? '1 : ent_sum[SUM_W-1:0];
    cmb_new = cmb_sum[SUM_W] ? '1 : cmb_sum[SUM_W-1:0];
  end

  // smoothing term and final clamp
  assign smooth_den = SIZE_W'(SMOOTH_Q24) * SIZE_W'(var_card_r);

  always_comb begin
    if (div_rsp.quotient < CLAMP_LOW) begin
      prob_clamped = CLAMP_LOW;
    end else if (div_rsp.quotient > CLAMP_HIGH) begin
      prob_clamped = CLAMP_HIGH;
    end else begin
      prob_clamped = div_rsp.quotient;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = clear_reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.data.operation)
            OP_CLEAR:  state_nxt = ST_CLEAR;
            OP_SAMPLE: state_nxt = ST_COMBO;
            OP_READ:   state_nxt = read_bad ? ST_DONE : ST_REM;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_COMBO: begin
        if (k_r == SLOT_W'(PARENT_SLOTS - 1)) begin
          state_nxt = ST_INDEX;
        end
      end
      ST_INDEX:  state_nxt = sample_bad ? ST_DONE : ST_FETCH;
      ST_REM: begin
        if (div_rsp.done) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH:  state_nxt = (item_r.operation == OP_SAMPLE) ? ST_UPDATE : ST_PREP;
      ST_UPDATE: state_nxt = ST_DONE;
      ST_PREP:   state_nxt = ST_FRAC;
      ST_FRAC:   state_nxt = (num_r >= den_r) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    ent_we    = 1'b0;
    cmb_we    = 1'b0;
    ent_waddr = ent_addr_r;
    cmb_waddr = cmb_addr_r;
    ent_wdata = ent_new;
    cmb_wdata = cmb_new;
    div_req   = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ent_we    = 1'b1;
        cmb_we    = 1'b1;
        ent_waddr = clr_cnt_r;
        cmb_waddr = clr_cnt_r;
        ent_wdata = '0;
        cmb_wdata = '0;
      end
      ST_IDLE: begin
        // remainder of entry index by parent span gives the combination
        div_req.start     = in_acc && (in_ch.data.operation == OP_READ) && !read_bad;
        div_req.steps     = REM_STEPS;
        div_req.bits_init = {in_ch.data.entry_index, (QUO_W-ENTRY_W)'(0)};
        div_req.divisor   = DIV_W'(span_r);
      end
      ST_UPDATE: begin
        ent_we = 1'b1;
        cmb_we = 1'b1;
      end
      ST_FRAC: begin
        div_req.start    = num_r < den_r;
        div_req.steps    = FRAC_STEPS;
        div_req.rem_init = num_r;
        div_req.divisor  = den_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_cnt_r     <= '0;
      clear_reply_r <= 1'b0;
      k_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (in_acc) begin
        k_r <= '0;
        if (in_ch.data.operation == OP_CLEAR) begin
          clr_cnt_r     <= '0;
          clear_reply_r <= 1'b1;
        end
      end
      if (state_r == ST_COMBO) begin
        k_r <= k_r + SLOT_W'(1);
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r       <= in_ch.data;
      res_prob_r   <= '0;
      res_status_r <= ((in_ch.data.operation == OP_READ) && read_bad)
                   || ((in_ch.data.operation != OP_CLEAR)
                   && (in_ch.data.operation != OP_SAMPLE)
                   && (in_ch.data.operation != OP_READ));
      combo_r      <= '0;
      combo_ok_r   <= 1'b1;
      ent_addr_r   <= AW'(in_ch.data.entry_index);
    end
    if (state_r == ST_COMBO && use_slot) begin
      combo_r    <= combo_step;
      combo_ok_r <= combo_ok_r && pv_ok;
    end
    if (state_r == ST_INDEX) begin
      res_status_r <= sample_bad;
      ent_addr_r   <= AW'(idx_full);
      cmb_addr_r   <= AW'(combo_r);
    end
    if (state_r == ST_REM && div_rsp.done) begin
      cmb_addr_r <= AW'(div_rsp.remainder);
    end
    if (state_r == ST_PREP) begin
      num_r <= DIV_W'({ent_rdata, 8'h00}) + DIV_W'(SMOOTH_Q24);
      den_r <= DIV_W'({cmb_rdata, 8'h00}) + DIV_W'(smooth_den);
    end
    if (state_r == ST_FRAC && num_r >= den_r) begin
      res_prob_r <= CLAMP_HIGH;
    end
    if (state_r == ST_DIV && div_rsp.done) begin
      res_prob_r <= prob_clamped;
    end
    if (state_r == ST_DONE && out_free) begin
      out_r.probability <= res_prob_r;
      out_r.status      <= res_status_r;
    end
  end

  // count memories; one item at a time, so a read never overlaps a write
  sce_count_mem #(.DEPTH(TABLE_DEPTH)) u_ent_mem (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_addr_r),
    .rdata (ent_rdata)
  );

  sce_count_mem #(.DEPTH(TABLE_DEPTH)) u_cmb_mem (
    .clk   (clk),
    .we    (cmb_we),
    .waddr (cmb_waddr),
    .wdata (cmb_wdata),
    .raddr (cmb_addr_r),
    .rdata (cmb_rdata)
  );

  // shared divider for the combination remainder and the probability fraction
  sce_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // memories are written only by the clear sweep or a sample update
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    (ent_we || cmb_we) |-> (state_r == ST_CLEAR || state_r == ST_UPDATE))
    else $error("count memory written outside clear or update");

  // no item is taken right after a register write
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> !in_rdy)
    else $error("item accepted while table geometry settles");

  // a nonzero ok probability lies inside the clamp bounds
  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.status && out_r.probability != '0)
      |-> (out_r.probability >= CLAMP_LOW && out_r.probability <= CLAMP_HIGH))
    else $error("probability outside clamp bounds");

  // a finished result reaches the output register when it is free
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded into free output register");

  // the divider is never restarted while busy
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire
